FILE: rtl/pmsa_pkg.sv
package pmsa_pkg;

    // width of the slot number carried in a result
    localparam int SLOT_OUT_W = 10;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_FLAGS = 2'd1;

    // protection flags after reset
    localparam logic [9:0] ENTRY_FLAGS_RST = 10'd99;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_UNMAP = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_UNMAP
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] phys_addr;
        logic [31:0] virt_addr;
        logic [1:0]  requester;
    } t_request;

    typedef struct packed {
        logic [31:0]           mapped_addr;
        logic [31:0]           entry_value;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  flush_tlb;
        t_status               status;
    } t_result;

    // one slot in the slot memory; a ready mark whose epoch differs from
    // the current epoch has been freed by a later wrap
    typedef struct packed {
        logic occ;
        logic rdy;
        logic ep;
    } t_slot_entry;

endpackage

FILE: rtl/pmsa_slot_mem.sv
module pmsa_slot_mem #(
    parameter int SLOTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]   i_rd_addr,
    output pmsa_pkg::t_slot_entry      o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]   i_wr_addr,
    input  pmsa_pkg::t_slot_entry      i_wr_data
);

    pmsa_pkg::t_slot_entry r_mem [SLOTS];
    pmsa_pkg::t_slot_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/pmsa_ctrl.sv
module pmsa_ctrl #(
    parameter int SLOTS      = 1024,
    parameter int PAGE_BITS  = 12,
    parameter int REQUESTERS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  pmsa_pkg::t_request         i_request,
    input  logic [31:0]                i_window_base,
    input  logic [9:0]                 i_entry_flags,
    output logic                       o_done,
    output pmsa_pkg::t_result          o_result,
    output logic                       o_mem_rd_en,
    output logic [$clog2(SLOTS)-1:0]   o_mem_rd_addr,
    input  pmsa_pkg::t_slot_entry      i_mem_rd_data,
    output logic                       o_mem_wr_en,
    output logic [$clog2(SLOTS)-1:0]   o_mem_wr_addr,
    output pmsa_pkg::t_slot_entry      o_mem_wr_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int RW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
    localparam int PW = 32 - PAGE_BITS;
    localparam int SW = pmsa_pkg::SLOT_OUT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [31:0] OFFSET_MASK = (32'd1 << PAGE_BITS) - 32'd1;

    pmsa_pkg::t_state r_state, n_state;

    // control state
    logic [AW-1:0]  r_cursor;
    logic           r_epoch;
    logic [AW-1:0]  r_seen [REQUESTERS];
    logic           r_iss_on;
    logic           r_ev_vld;
    logic [AW-1:0]  r_clr_addr;
    logic           r_done;

    // request and scan payload
    pmsa_pkg::t_request r_req;
    logic [RW-1:0]  r_reqm;
    logic           r_flush0;
    logic [AW-1:0]  r_iss_addr;
    logic           r_iss_ep;
    logic           r_iss_flush;
    logic [AW-1:0]  r_iss_cnt;
    logic [AW-1:0]  r_ev_addr;
    logic           r_ev_ep;
    logic           r_ev_flush;
    logic           r_ev_last;
    pmsa_pkg::t_result r_result;

    logic           accept;
    logic [4:0]     req_v;
    logic [RW-1:0]  reqm;
    logic [AW-1:0]  iss_addr_nx;
    logic           iss_wrap;
    logic           ev_free;
    logic           found;
    logic           full;
    logic           issue;
    logic [31:0]    um_off;
    logic [PW-1:0]  um_page;
    logic           um_bad;
    logic [AW-1:0]  um_idx;
    logic [AW+SW-1:0] ev_slot_ext;
    logic [AW+SW-1:0] um_slot_ext;
    logic [31:0]    map_addr;
    logic [31:0]    map_entry;

    assign accept = i_start && (r_state == pmsa_pkg::S_IDLE);

    // requester number reduced into the table range
    always_comb begin
        req_v = {3'b000, i_request.requester};
        for (int k = 0; k < 3; k++) begin
            if (req_v >= 5'(REQUESTERS)) begin
                req_v = req_v - 5'(REQUESTERS);
            end
        end
        reqm = req_v[RW-1:0];
    end

    // cursor step for the next read of the scan
    assign iss_addr_nx = (r_iss_addr == LAST_SLOT) ? '0 : r_iss_addr + 1'b1;
    assign iss_wrap    = (iss_addr_nx == '0);

    // slot is free when its ready mark is from another epoch, else when it is not occupied
    assign ev_free = i_mem_rd_data.rdy ? (i_mem_rd_data.ep != r_ev_ep)
                                       : !i_mem_rd_data.occ;
    assign found = (r_state == pmsa_pkg::S_MAP) && r_ev_vld && ev_free;
    assign full  = (r_state == pmsa_pkg::S_MAP) && r_ev_vld && !ev_free && r_ev_last;
    assign issue = (r_state == pmsa_pkg::S_MAP) && r_iss_on && !found;

    // unmap address decode
    assign um_off  = r_req.virt_addr - i_window_base;
    assign um_page = um_off[31:PAGE_BITS];
    assign um_bad  = (um_page >= PW'(SLOTS));
    assign um_idx  = um_page[AW-1:0];

    assign ev_slot_ext = {{SW{1'b0}}, r_ev_addr};
    assign um_slot_ext = {{SW{1'b0}}, um_idx};

    // mapped address and page table entry
    assign map_addr  = i_window_base
                     + ((32'(r_ev_addr) << PAGE_BITS) | (r_req.phys_addr & OFFSET_MASK));
    assign map_entry = (r_req.phys_addr & ~OFFSET_MASK) | 32'(i_entry_flags);

    // next state and memory port control
    always_comb begin
        n_state       = r_state;
        o_mem_rd_en   = issue;
        o_mem_rd_addr = iss_addr_nx;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_ev_addr;
        o_mem_wr_data = '0;
        unique case (r_state)
            pmsa_pkg::S_CLEAR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_clr_addr;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = pmsa_pkg::S_IDLE;
                end
            end
            pmsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_request.opcode == pmsa_pkg::OP_MAP) ? pmsa_pkg::S_MAP
                                                                     : pmsa_pkg::S_UNMAP;
                end
            end
            pmsa_pkg::S_MAP: begin
                if (found) begin
                    o_mem_wr_en       = 1'b1;
                    o_mem_wr_addr     = r_ev_addr;
                    o_mem_wr_data.occ = 1'b1;
                    o_mem_wr_data.rdy = 1'b0;
                    o_mem_wr_data.ep  = r_ev_ep;
                    n_state           = pmsa_pkg::S_IDLE;
                end else if (full) begin
                    n_state = pmsa_pkg::S_IDLE;
                end
            end
            pmsa_pkg::S_UNMAP: begin
                if (!um_bad) begin
                    o_mem_wr_en       = 1'b1;
                    o_mem_wr_addr     = um_idx;
                    o_mem_wr_data.occ = 1'b1;
                    o_mem_wr_data.rdy = 1'b1;
                    o_mem_wr_data.ep  = r_epoch;
                end
                n_state = pmsa_pkg::S_IDLE;
            end
            default: n_state = pmsa_pkg::S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // cursor, epoch, seen table and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_epoch    <= 1'b0;
            r_iss_on   <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            for (int i = 0; i < REQUESTERS; i++) begin
                r_seen[i] <= '0;
            end
        end else begin
            r_done   <= found || full || (r_state == pmsa_pkg::S_UNMAP);
            r_ev_vld <= issue;
            if (r_state == pmsa_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (accept && (i_request.opcode == pmsa_pkg::OP_MAP)) begin
                r_iss_on <= 1'b1;
            end
            if (issue && (r_iss_cnt == LAST_SLOT)) begin
                r_iss_on <= 1'b0;
            end
            if (found) begin
                r_iss_on       <= 1'b0;
                r_cursor       <= r_ev_addr;
                r_epoch        <= r_ev_ep;
                r_seen[r_reqm] <= r_ev_addr;
            end
            if (full) begin
                r_epoch <= r_ev_ep;
            end
        end
    end

    // request capture, scan pipeline and result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= i_request;
            r_reqm      <= reqm;
            r_flush0    <= (r_cursor < r_seen[reqm]);
            r_iss_addr  <= r_cursor;
            r_iss_ep    <= r_epoch;
            r_iss_flush <= 1'b0;
            r_iss_cnt   <= '0;
        end
        if (issue) begin
            r_iss_addr  <= iss_addr_nx;
            r_iss_ep    <= r_iss_ep ^ iss_wrap;
            r_iss_flush <= r_iss_flush | iss_wrap;
            r_iss_cnt   <= r_iss_cnt + 1'b1;
            r_ev_addr   <= iss_addr_nx;
            r_ev_ep     <= r_iss_ep ^ iss_wrap;
            r_ev_flush  <= r_iss_flush | iss_wrap;
            r_ev_last   <= (r_iss_cnt == LAST_SLOT);
        end
        if (found) begin
            r_result.mapped_addr <= map_addr;
            r_result.entry_value <= map_entry;
            r_result.slot        <= ev_slot_ext[SW-1:0];
            r_result.flush_tlb   <= r_flush0 | r_ev_flush;
            r_result.status      <= pmsa_pkg::ST_OK;
        end else if (full) begin
            r_result.mapped_addr <= '0;
            r_result.entry_value <= '0;
            r_result.slot        <= '0;
            r_result.flush_tlb   <= r_flush0 | r_ev_flush;
            r_result.status      <= pmsa_pkg::ST_FULL;
        end else if (r_state == pmsa_pkg::S_UNMAP) begin
            r_result.mapped_addr <= '0;
            r_result.entry_value <= '0;
            r_result.flush_tlb   <= 1'b0;
            r_result.slot        <= um_bad ? '0 : um_slot_ext[SW-1:0];
            r_result.status      <= um_bad ? pmsa_pkg::ST_BAD_ADDR : pmsa_pkg::ST_OK;
        end
    end

    assign o_busy   = (r_state != pmsa_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // a result only follows a map or unmap state
    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == pmsa_pkg::S_MAP || $past(r_state) == pmsa_pkg::S_UNMAP))
        else $error("result strobe without a request in progress");

    // scan reads are only evaluated inside a map
    a_ev_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == pmsa_pkg::S_MAP))
        else $error("slot read evaluated outside a map");

    // the cursor moves only when a map finds a slot
    a_cursor_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cursor) |-> ($past(r_state) == pmsa_pkg::S_MAP))
        else $error("cursor moved outside a map");

    // an idle block leaves the slot memory alone
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmsa_pkg::S_IDLE) |-> !o_mem_wr_en)
        else $error("slot memory written while idle");

    // a successful map reports the slot the cursor now points at
    a_map_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        found |=> (r_done && r_result.status == pmsa_pkg::ST_OK && r_cursor == $past(r_ev_addr)))
        else $error("map result does not match the cursor");

endmodule

FILE: rtl/page_map_slot_allocator.sv
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+-----------------------------
// request   | in        | start high, busy low           | i_request (t_request)
// result    | out       | o_done, one cycle, no stall    | o_result (t_result)
// config    | in        | i_cfg_valid and o_cfg_ready    | i_cfg_index, i_cfg_data
//
// unmap: accept moves to the unmap state, which registers the result strobe; busy drops as the strobe shows.
// map: the cursor steps up to the first free slot, SLOTS steps when the ring
// is full; one slot memory read per step through the single read port.
// after reset the slot memory is cleared one entry a cycle, with busy high.
// the result is a one-cycle strobe; the receiver cannot stall it.
module page_map_slot_allocator #(
    parameter int SLOTS      = 1024,
    parameter int PAGE_BITS  = 12,
    parameter int REQUESTERS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pmsa_pkg::t_request                i_request,
    output logic                              o_done,
    output pmsa_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pmsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    localparam int AW = $clog2(SLOTS);

    logic [31:0] r_window_base;
    logic [9:0]  r_entry_flags;

    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    pmsa_pkg::t_slot_entry mem_rd_data;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    pmsa_pkg::t_slot_entry mem_wr_data;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= '0;
            r_entry_flags <= pmsa_pkg::ENTRY_FLAGS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pmsa_pkg::CFG_WINDOW_BASE: r_window_base <= i_cfg_data;
                pmsa_pkg::CFG_ENTRY_FLAGS: r_entry_flags <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    pmsa_ctrl #(
        .SLOTS      (SLOTS),
        .PAGE_BITS  (PAGE_BITS),
        .REQUESTERS (REQUESTERS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_request     (i_request),
        .i_window_base (r_window_base),
        .i_entry_flags (r_entry_flags),
        .o_done        (o_done),
        .o_result      (o_result),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data)
    );

    pmsa_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

endmodule

FILE: verif/page_map_slot_allocator_tb.sv
`timescale 1ns / 100ps

module page_map_slot_allocator_tb;

    localparam int SLOTS      = 1024;
    localparam int PAGE_BITS  = 12;
    localparam int REQUESTERS = 4;
    localparam int CLK_PERIOD = 2;
    localparam int SLOT_W     = pmsa_pkg::SLOT_OUT_W;

    localparam logic [31:0] OFFSET_MASK = (32'd1 << PAGE_BITS) - 32'd1;

    // register indexes past the end of the register list, writes are dropped
    localparam logic [pmsa_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [pmsa_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    // every request at its slowest: a full ring pass plus the longest gap,
    // over a generous request count, then several times over
    localparam int unsigned LIMIT_CYCLES = 4 * 1600 * (SLOTS + 16) + 2 * SLOTS;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    pmsa_pkg::t_request i_request;
    logic               o_done;
    pmsa_pkg::t_result  o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [pmsa_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]        i_cfg_data;

    // shadow copy of the allocator state
    bit          slot_occupied [SLOTS];
    bit          slot_ready [SLOTS];
    int unsigned ring_cursor;
    int unsigned cursor_seen [REQUESTERS];
    logic [31:0] shadow_base  = 32'd0;
    logic [9:0]  shadow_flags = pmsa_pkg::ENTRY_FLAGS_RST;

    pmsa_pkg::t_result pending_results [$];
    logic [31:0]       live_mappings [$];
    pmsa_pkg::t_status last_status = pmsa_pkg::ST_OK;
    int unsigned calm_left;
    int unsigned mismatches;

    page_map_slot_allocator #(
        .SLOTS      (SLOTS),
        .PAGE_BITS  (PAGE_BITS),
        .REQUESTERS (REQUESTERS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_request   (i_request),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // expected result of one request, advancing the shadow state
    task automatic predict_request(input pmsa_pkg::t_request rq,
                                   output pmsa_pkg::t_result res);
        logic [31:0] offset;
        int unsigned who;
        int unsigned page;
        bit          found;
        who = rq.requester % REQUESTERS;
        res = '0;
        res.status = pmsa_pkg::ST_OK;
        if (rq.opcode == pmsa_pkg::OP_MAP) begin
            found = 1'b0;
            res.flush_tlb = (ring_cursor < cursor_seen[who]);
            for (int n = 0; n < SLOTS && !found; n++) begin
                ring_cursor = (ring_cursor + 1) % SLOTS;
                // wrap to slot 0: every slot marked ready is released
                if (ring_cursor == 0) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (slot_ready[s]) begin
                            slot_ready[s]    = 1'b0;
                            slot_occupied[s] = 1'b0;
                        end
                    end
                    res.flush_tlb = 1'b1;
                end
                found = !slot_occupied[ring_cursor] && !slot_ready[ring_cursor];
            end
            if (found) begin
                slot_occupied[ring_cursor] = 1'b1;
                cursor_seen[who] = ring_cursor;
                res.entry_value = (rq.phys_addr & ~OFFSET_MASK) | 32'(shadow_flags);
                res.mapped_addr = shadow_base + (32'(ring_cursor) << PAGE_BITS)
                                  + (rq.phys_addr & OFFSET_MASK);
                res.slot = SLOT_W'(ring_cursor);
            end else begin
                res.status = pmsa_pkg::ST_FULL;
            end
        end else begin
            offset = rq.virt_addr - shadow_base;
            page = offset >> PAGE_BITS;
            if (page >= SLOTS) begin
                res.status = pmsa_pkg::ST_BAD_ADDR;
            end else begin
                slot_ready[page] = 1'b1;
                res.slot = SLOT_W'(page);
            end
        end
    endtask

    // unused fields carry noise
    function automatic pmsa_pkg::t_request map_request(input logic [31:0] pa,
                                                       input logic [1:0] who);
        pmsa_pkg::t_request rq;
        rq.opcode    = pmsa_pkg::OP_MAP;
        rq.phys_addr = pa;
        rq.virt_addr = $urandom;
        rq.requester = who;
        return rq;
    endfunction

    function automatic pmsa_pkg::t_request unmap_request(input logic [31:0] va);
        pmsa_pkg::t_request rq;
        rq.opcode    = pmsa_pkg::OP_UNMAP;
        rq.phys_addr = $urandom;
        rq.virt_addr = va;
        rq.requester = 2'($urandom_range(0, 3));
        return rq;
    endfunction

    // a live mapping with live_pct percent odds, else a random page in the window or any address
    function automatic logic [31:0] pick_unmap_addr(input int unsigned live_pct);
        int unsigned roll;
        int unsigned pos;
        logic [31:0] addr;
        roll = $urandom_range(0, 99);
        if (roll < live_pct && live_mappings.size() > 0) begin
            pos = $urandom_range(0, live_mappings.size() - 1);
            addr = live_mappings[pos];
            live_mappings.delete(pos);
        end else if (roll < 90) begin
            addr = shadow_base + (32'($urandom_range(0, SLOTS - 1)) << PAGE_BITS)
                   + ($urandom & OFFSET_MASK);
        end else begin
            addr = $urandom;
        end
        return addr;
    endfunction

    // send one request after a random gap, record what it must return
    task automatic issue_request(input pmsa_pkg::t_request rq);
        int unsigned       gap;
        pmsa_pkg::t_result want;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 31) == 0)
                calm_left = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_request = rq;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_request(rq, want);
        pending_results.push_back(want);
        last_status = want.status;
        if (rq.opcode == pmsa_pkg::OP_MAP && want.status == pmsa_pkg::ST_OK)
            live_mappings.push_back(want.mapped_addr);
        @(negedge i_clk);
    endtask

    // drop start, let every outstanding result arrive and the block go quiet
    task automatic wait_until_idle();
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [pmsa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        wait_until_idle();
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pmsa_pkg::CFG_WINDOW_BASE: begin
                shadow_base = data;
                live_mappings.delete();
            end
            pmsa_pkg::CFG_ENTRY_FLAGS: shadow_flags = data[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare every strobed result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        pmsa_pkg::t_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p", $time, o_result);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("mapped_addr", want.mapped_addr, o_result.mapped_addr);
                check_field("entry_value", want.entry_value, o_result.entry_value);
                check_field("slot", 32'(want.slot), 32'(o_result.slot));
                check_field("flush_tlb", 32'(want.flush_tlb), 32'(o_result.flush_tlb));
                check_field("status", 32'(want.status), 32'(o_result.status));
            end
        end
    end

    // field extremes, window edges, unmap of a never mapped page, spare indexes
    task automatic test_directed_cases();
        issue_request(map_request(32'h0000_0000, 2'd0));
        issue_request(map_request(32'hFFFF_FFFF, 2'd3));
        issue_request(map_request(32'h1234_5ABC, 2'd1));
        issue_request(map_request(32'h8000_0FFF, 2'd2));
        issue_request(unmap_request(32'h0000_1000));
        // last page of the window, never mapped: parked until the next wrap
        issue_request(unmap_request(32'h003F_FFFF));
        issue_request(unmap_request(32'h0040_0000));
        issue_request(unmap_request(32'hFFFF_FFFF));
        issue_request(unmap_request(32'h0000_2ABC));

        // window at the top of the address space, mapped address wraps
        write_register(pmsa_pkg::CFG_WINDOW_BASE, 32'hFFFF_F000);
        write_register(pmsa_pkg::CFG_ENTRY_FLAGS, 32'h0000_0000);
        issue_request(map_request(32'h0000_0FFF, 2'd1));
        issue_request(unmap_request(32'hFFFF_EFFF));
        issue_request(unmap_request(32'hFFFF_F000));
        issue_request(unmap_request(32'h003F_EFFF));
        issue_request(unmap_request(32'h003F_F000));

        write_register(pmsa_pkg::CFG_WINDOW_BASE, 32'hFFFF_FFFF);
        write_register(pmsa_pkg::CFG_ENTRY_FLAGS, 32'h0000_03FF);
        issue_request(map_request(32'hFFFF_FFFF, 2'd3));
        issue_request(map_request(32'h5555_5AAA, 2'd0));

        // writes past the register list leave both registers alone
        write_register(CFG_IDX_SPARE_LO, 32'hAAAA_AAAA);
        write_register(CFG_IDX_SPARE_HI, 32'h5555_5555);
        issue_request(map_request(32'hAAAA_A555, 2'd2));
        issue_request(unmap_request(32'hFFFF_FFFF));
    endtask

    // mixed map and unmap traffic under a run of register settings
    task automatic test_random_traffic();
        logic [31:0] base_pick;
        logic [31:0] flags_pick;
        for (int chunk = 0; chunk < 6; chunk++) begin
            flags_pick = $urandom_range(0, 1023);
            case (chunk)
                0: begin
                    base_pick  = 32'h0000_0000;
                    flags_pick = 32'h0000_03FF;
                end
                1: begin
                    base_pick  = 32'hFFFF_F000;
                    flags_pick = 32'h0000_0000;
                end
                2: base_pick = $urandom & ~OFFSET_MASK;
                3: base_pick = $urandom;
                4: base_pick = 32'hFFC0_0000;
                default: begin
                    base_pick  = $urandom & ~OFFSET_MASK;
                    flags_pick = 32'(pmsa_pkg::ENTRY_FLAGS_RST);
                end
            endcase
            write_register(pmsa_pkg::CFG_WINDOW_BASE, base_pick);
            write_register(pmsa_pkg::CFG_ENTRY_FLAGS, flags_pick);
            if (chunk == 2) begin
                write_register(CFG_IDX_SPARE_LO, $urandom);
                write_register(CFG_IDX_SPARE_HI, $urandom);
            end
            repeat (50) begin
                if ($urandom_range(0, 99) < 60)
                    issue_request(map_request($urandom, 2'($urandom_range(0, 3))));
                else
                    issue_request(unmap_request(pick_unmap_addr(50)));
            end
        end
    endtask

    // map until the ring reports full, then keep asking
    task automatic test_ring_exhaustion();
        int unsigned guard;
        write_register(pmsa_pkg::CFG_WINDOW_BASE, $urandom & ~OFFSET_MASK);
        write_register(pmsa_pkg::CFG_ENTRY_FLAGS, $urandom_range(0, 1023));
        guard = 0;
        last_status = pmsa_pkg::ST_OK;
        while (last_status != pmsa_pkg::ST_FULL && guard < 3 * SLOTS) begin
            issue_request(map_request($urandom, 2'($urandom_range(0, 3))));
            guard++;
        end
        issue_request(map_request($urandom, 2'd0));
        issue_request(map_request($urandom, 2'd3));
        issue_request(unmap_request(shadow_base - 32'd1));
    endtask

    // full ring: each unmap inside the window frees its page, picked up after the next wrap
    task automatic test_recycle_when_full();
        repeat (150) begin
            if ($urandom_range(0, 1) == 0)
                issue_request(unmap_request(pick_unmap_addr(85)));
            else
                issue_request(map_request($urandom, 2'($urandom_range(0, 3))));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_request   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pmsa_pkg::CFG_WINDOW_BASE;
        i_cfg_data  = '0;
        calm_left   = 0;
        mismatches  = 0;
        ring_cursor = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_ring_exhaustion();
        test_recycle_when_full();

        // drain, then watch a full ring pass for stray strobes
        wait_until_idle();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pmsa_pkg.sv
rtl/pmsa_slot_mem.sv
rtl/pmsa_ctrl.sv
rtl/page_map_slot_allocator.sv
verif/page_map_slot_allocator_tb.sv
